### rtl/core/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SEXPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication.
`define SEXPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

### rtl/core/sexpr_pkg.sv
// Package for the s-expression tokenizer: character codes, flag and result types,
// and the small character helper functions. Depends on nothing.
`default_nettype none

package sexpr_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_B  = 8'h62;

    localparam int          PADDR_W        = 3;
    localparam logic [0:0]  REG_COMMENTS   = 1'b0;

    typedef struct packed {
        logic quote_open;
        logic escape_pending;
        logic token_open;
        logic comment_open;
        logic depth_overflow;
    } flags_t;

    typedef struct packed {
        logic       has_result;
        logic       char_valid;
        logic [7:0] out_char;
        logic       token_end;
        logic       text_done;
        logic       text_error;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LOW_T: r = CH_TAB;
            CH_LOW_N: r = CH_LF;
            CH_LOW_V: r = CH_VT;
            CH_LOW_F: r = CH_FF;
            CH_LOW_R: r = CH_CR;
            CH_LOW_B: r = CH_BS;
            default:  r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sexpr_step.sv
// Per-character update of the tokenizer: next bracket depth, next flags and result.
// Purely combinational; uses sexpr_pkg.
`default_nettype none

module sexpr_step #(
    parameter int MAX_DEPTH = 255,
    parameter int DEPTH_W   = 9
) (
    input  wire logic                      comments_enabled,
    input  wire logic [7:0]                char_in,
    input  wire logic                      end_of_text,
    input  wire logic signed [DEPTH_W-1:0] depth,
    input  wire sexpr_pkg::flags_t         flags,
    output logic signed [DEPTH_W-1:0]      depth_next,
    output sexpr_pkg::flags_t              flags_next,
    output sexpr_pkg::result_t             result
);
    import sexpr_pkg::*;

    localparam logic signed [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_DEPTH);
    localparam logic signed [DEPTH_W-1:0] DEPTH_BOT = -DEPTH_TOP;
    localparam logic signed [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    logic eot;
    logic cmt_cur;
    logic cmt_new;
    logic ws;
    logic balanced;

    always_comb begin
        eot      = end_of_text || (char_in == CH_NUL);
        cmt_cur  = comments_enabled && flags.comment_open;
        balanced = (depth == '0) && !flags.quote_open && !flags.escape_pending;
        ws       = is_space(char_in);

        cmt_new = cmt_cur;
        if (comments_enabled) begin
            if ((char_in == CH_LF) && cmt_cur) begin
                cmt_new = 1'b0;
            end else if (!flags.quote_open && (char_in == CH_SEMI)) begin
                cmt_new = 1'b1;
            end
        end

        depth_next              = depth;
        flags_next              = flags;
        flags_next.comment_open = cmt_new;
        result                  = '0;

        if (eot) begin
            depth_next        = '0;
            flags_next        = '0;
            result.has_result = 1'b1;
            result.text_done  = 1'b1;
            result.token_end  = flags.token_open && balanced;
            result.text_error = !balanced || flags.depth_overflow;
        end else if (cmt_new) begin
            result = '0;
        end else if (ws && balanced) begin
            if (flags.token_open) begin
                flags_next.token_open = 1'b0;
                result.has_result     = 1'b1;
                result.token_end      = 1'b1;
            end
        end else begin
            flags_next.token_open = 1'b1;
            if (flags.escape_pending) begin
                flags_next.escape_pending = 1'b0;
                result.has_result         = 1'b1;
                result.char_valid         = 1'b1;
                result.out_char           = unescape(char_in);
            end else if (char_in == CH_BSLASH) begin
                flags_next.escape_pending = 1'b1;
            end else begin
                if (!flags.quote_open) begin
                    if (char_in == CH_LPAREN) begin
                        if (depth >= DEPTH_TOP) begin
                            flags_next.depth_overflow = 1'b1;
                        end else begin
                            depth_next = depth + DEPTH_ONE;
                        end
                    end else if (char_in == CH_RPAREN) begin
                        if (depth <= DEPTH_BOT) begin
                            flags_next.depth_overflow = 1'b1;
                        end else begin
                            depth_next = depth - DEPTH_ONE;
                        end
                    end
                end
                if (char_in == CH_QUOTE) begin
                    flags_next.quote_open = !flags.quote_open;
                end
                result.has_result = 1'b1;
                result.char_valid = 1'b1;
                result.out_char   = char_in;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/sexpr_top_level_tokenizer.sv
// Top level of the s-expression tokenizer: request channels, APB register, state
// and result registers. Uses sexpr_pkg, sexpr_step and assert_macros.svh.
//
// One character request enters on the s_ channel per cycle; s_ready is high
// whenever the result register is empty or is being drained by m_ready.
// A character that yields a result shows it on the m_ channel in the cycle
// after acceptance; characters that yield none (whitespace between tokens,
// comment text, an escaping backslash) leave the m_ channel untouched.
// Sustained throughput is one character per cycle while m_ready stays high,
// set by the single result register and the registered depth and flags.
// End of input (end_of_text, or a zero byte) always yields a result with
// text_done, reports imbalance or depth overflow on text_error, and clears the
// parse state so the next character starts a new text.
// When the receiver stalls, the pending result holds and s_ready drops until
// it is taken. Reset clears all parse state, empties the result register and
// sets comments_enabled (APB address 0, bit 0) to one. No clearing pass runs.
`default_nettype none

module sexpr_top_level_tokenizer #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_char_in,
    input  wire logic                           s_end_of_text,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_char_valid,
    output logic [7:0]                          m_out_char,
    output logic                                m_token_end,
    output logic                                m_text_done,
    output logic                                m_text_error,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sexpr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sexpr_pkg::*;

    `include "assert_macros.svh"

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1) + 1;
    localparam logic signed [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_DEPTH);

    logic                      comments_enabled_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic signed [DEPTH_W-1:0] depth_next;
    flags_t                    flags_reg;
    flags_t                    flags_next;
    result_t                   step_result;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   out_reg;
    logic                      accept;
    logic                      cfg_write;
    logic                      cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[PADDR_W-1] == REG_COMMENTS);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? {31'b0, comments_enabled_reg} : 32'b0;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sexpr_step #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W)
    ) u_step (
        .comments_enabled (comments_enabled_reg),
        .char_in          (s_char_in),
        .end_of_text      (s_end_of_text),
        .depth            (depth_reg),
        .flags            (flags_reg),
        .depth_next       (depth_next),
        .flags_next       (flags_next),
        .result           (step_result)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (accept) begin
            out_valid_next = step_result.has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comments_enabled_reg <= 1'b1;
            depth_reg            <= '0;
            flags_reg            <= '0;
            out_valid_reg        <= 1'b0;
        end else begin
            if (cfg_write && cfg_hit) begin
                comments_enabled_reg <= pwdata[0];
            end
            if (accept) begin
                depth_reg <= depth_next;
                flags_reg <= flags_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step_result.has_result) begin
            out_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_char_valid = out_reg.char_valid;
    assign m_out_char   = out_reg.out_char;
    assign m_token_end  = out_reg.token_end;
    assign m_text_done  = out_reg.text_done;
    assign m_text_error = out_reg.text_error;

    `SEXPR_ASSERT_NEXT(a_eot_clears, accept && (s_end_of_text || (s_char_in == CH_NUL)),
        (depth_reg == '0) && (flags_reg == '0))
    `SEXPR_ASSERT_NOW(a_depth_bound, 1'b1,
        (depth_reg <= DEPTH_TOP) && (depth_reg >= -DEPTH_TOP))
    `SEXPR_ASSERT_NOW(a_error_with_done, m_valid && m_text_error, m_text_done)
    `SEXPR_ASSERT_NOW(a_char_excl, m_valid && m_char_valid,
        !m_token_end && !m_text_done)

endmodule

`default_nettype wire
